@@ hw/rtl/asd_pkg.sv @@
// package: shared constants and types of the audio streaming descriptor parser
package asd_pkg;

  localparam int CAPTURE_DEPTH = 11;
  localparam int CAP_IDX_W     = $clog2(CAPTURE_DEPTH);

  localparam logic [7:0] CS_IFACE_TYPE     = 8'h24;
  localparam logic [7:0] SUB_STREAM_GEN    = 8'h01;
  localparam logic [7:0] SUB_FORMAT        = 8'h02;
  localparam logic [7:0] FMT_TYPE_ONE      = 8'h01;
  localparam logic [7:0] MIN_DESC_LEN      = 8'd3;
  localparam logic [7:0] AS_GEN_FULL_LEN   = 8'd11;
  localparam logic [7:0] AS_GEN_SHORT_LEN  = 8'd7;
  localparam logic [7:0] FMT_SHORT_LEN     = 8'd6;
  localparam logic [7:0] FMT_LONG_LEN      = 8'd8;

  typedef struct packed {
    logic [7:0]  terminal_link;
    logic [7:0]  format_type;
    logic [31:0] format_mask;
    logic [7:0]  channel_count;
    logic [7:0]  subslot_size;
    logic [7:0]  resolution_bits;
  } held_t;

  typedef struct packed {
    held_t fields;
    logic  stopped_early;
  } result_t;

endpackage

@@ hw/rtl/asd_if.sv @@
// interfaces: byte request channel and result request channel
interface asd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface asd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  terminal_link;
  logic [7:0]  format_type;
  logic [31:0] format_mask;
  logic [7:0]  channel_count;
  logic [7:0]  subslot_size;
  logic [7:0]  resolution_bits;
  logic        stopped_early;

  modport source (output valid, output terminal_link, output format_type,
                  output format_mask, output channel_count, output subslot_size,
                  output resolution_bits, output stopped_early, input ready);
  modport sink   (input valid, input terminal_link, input format_type,
                  input format_mask, input channel_count, input subslot_size,
                  input resolution_bits, input stopped_early, output ready);
endinterface

@@ hw/rtl/asd_parser.sv @@
// parser: descriptor framing, byte capture and held field update per byte
module asd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_acc,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              res_valid,
  output asd_pkg::result_t  res_data
);

  localparam int IdxW = asd_pkg::CAP_IDX_W;

  logic [7:0]     off_r, off_nxt;
  logic [7:0]     len_r, len_nxt;
  logic           halted_r, halted_nxt;
  asd_pkg::held_t held_r, held_nxt;
  logic [7:0]     captured_r [asd_pkg::CAPTURE_DEPTH];
  logic [7:0]     cap_view   [asd_pkg::CAPTURE_DEPTH];
  logic           cap_we;
  logic           complete;
  logic [7:0]     off_inc;

  assign off_inc = off_r + 8'd1;

  // capture array as it looks with the current byte written
  always_comb begin
    for (int i = 0; i < asd_pkg::CAPTURE_DEPTH; i++) begin
      cap_view[i] = (cap_we && (off_r[IdxW-1:0] == IdxW'(i))) ? in_byte : captured_r[i];
    end
  end

  always_comb begin
    off_nxt    = off_r;
    len_nxt    = len_r;
    halted_nxt = halted_r;
    held_nxt   = held_r;
    cap_we     = 1'b0;
    complete   = 1'b0;
    res_data   = '0;

    if (halted_r) begin
      if (off_r < asd_pkg::MIN_DESC_LEN) off_nxt = off_inc;
    end else if (off_r == 8'd0) begin
      len_nxt = in_byte;
      off_nxt = 8'd1;
      cap_we  = 1'b1;
      if (in_byte < asd_pkg::MIN_DESC_LEN) halted_nxt = 1'b1;
    end else begin
      cap_we  = (off_r < 8'(asd_pkg::CAPTURE_DEPTH));
      off_nxt = off_inc;
      if (off_inc == len_r) begin
        complete = 1'b1;
        off_nxt  = 8'd0;
      end
    end

    if (complete && (cap_view[1] == asd_pkg::CS_IFACE_TYPE)) begin
      if (cap_view[2] == asd_pkg::SUB_STREAM_GEN) begin
        if (len_r >= asd_pkg::AS_GEN_FULL_LEN) begin
          held_nxt.terminal_link = cap_view[3];
          held_nxt.format_type   = cap_view[5];
          held_nxt.format_mask   = {cap_view[9], cap_view[8], cap_view[7], cap_view[6]};
          held_nxt.channel_count = cap_view[10];
        end else if (len_r >= asd_pkg::AS_GEN_SHORT_LEN) begin
          held_nxt.format_type = cap_view[3];
        end
      end else if ((cap_view[2] == asd_pkg::SUB_FORMAT) &&
                   (cap_view[3] == asd_pkg::FMT_TYPE_ONE)) begin
        if (len_r == asd_pkg::FMT_SHORT_LEN) begin
          held_nxt.format_type     = cap_view[3];
          held_nxt.subslot_size    = cap_view[4];
          held_nxt.resolution_bits = cap_view[5];
        end else if (len_r >= asd_pkg::FMT_LONG_LEN) begin
          held_nxt.format_type     = cap_view[3];
          held_nxt.channel_count   = cap_view[4];
          held_nxt.subslot_size    = cap_view[5];
          held_nxt.resolution_bits = cap_view[6];
        end
      end
    end

    res_data.fields        = held_nxt;
    res_data.stopped_early = halted_nxt && (off_nxt >= asd_pkg::MIN_DESC_LEN);

    // end of blob: back to the cleared state
    if (in_last) begin
      off_nxt    = 8'd0;
      len_nxt    = 8'd0;
      halted_nxt = 1'b0;
      held_nxt   = '0;
    end
  end

  assign res_valid = in_acc && in_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r    <= 8'd0;
      len_r    <= 8'd0;
      halted_r <= 1'b0;
      held_r   <= '0;
    end else if (in_acc) begin
      off_r    <= off_nxt;
      len_r    <= len_nxt;
      halted_r <= halted_nxt;
      held_r   <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && cap_we) begin
      captured_r[off_r[IdxW-1:0]] <= in_byte;
    end
  end

endmodule

@@ hw/rtl/asd_out_skid.sv @@
// result register with skid stage
module asd_out_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  asd_pkg::result_t  push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output asd_pkg::result_t  out_data
);

  logic             main_v_r;
  logic             skid_v_r;
  asd_pkg::result_t main_d_r;
  asd_pkg::result_t skid_d_r;
  logic             pop;

  assign pop       = main_v_r && out_ready;
  assign can_push  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        main_d_r <= skid_d_r;
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_d_r <= push_data;
        main_v_r <= 1'b1;
      end else begin
        skid_d_r <= push_data;
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/audio_streaming_descriptor_parser_core.sv @@
// top level: usb audio streaming descriptor parser core
//
//   channel | dir | handshake     | payload
//   in_ch   | in  | valid/ready   | data_byte[7:0], last_byte
//   out_ch  | out | valid/ready   | terminal_link, format_type, format_mask[31:0],
//           |     |               | channel_count, subslot_size, resolution_bits,
//           |     |               | stopped_early
//
// one byte accepted per cycle while in_ch.ready is high; framing and field update
// finish in the accepting cycle, and a last byte's result is registered for out_ch
// reset: synchronous active-low rst_n clears framing state, held fields and output
// a result register plus one skid entry hold results; in_ch.ready drops only while
// both are full
module audio_streaming_descriptor_parser_core (
  input  logic            clk,
  input  logic            rst_n,
  asd_in_if.sink          in_ch,
  asd_out_if.source       out_ch
);

  logic             in_acc;
  logic             res_valid;
  asd_pkg::result_t res_data;
  asd_pkg::result_t out_data;
  logic             can_push;

  assign in_ch.ready = can_push;
  assign in_acc      = in_ch.valid && can_push;

  asd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_byte   (in_ch.data_byte),
    .in_last   (in_ch.last_byte),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  asd_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.terminal_link   = out_data.fields.terminal_link;
  assign out_ch.format_type     = out_data.fields.format_type;
  assign out_ch.format_mask     = out_data.fields.format_mask;
  assign out_ch.channel_count   = out_data.fields.channel_count;
  assign out_ch.subslot_size    = out_data.fields.subslot_size;
  assign out_ch.resolution_bits = out_data.fields.resolution_bits;
  assign out_ch.stopped_early   = out_data.stopped_early;

endmodule

@@ hw/rtl/asd_checker.sv @@
// checker: port-level assertions for the parser core, with bind
module asd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_terminal_link,
  input logic [7:0]  out_format_type,
  input logic [31:0] out_format_mask,
  input logic [7:0]  out_channel_count,
  input logic [7:0]  out_subslot_size,
  input logic [7:0]  out_resolution_bits,
  input logic        out_stopped_early
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_terminal_link, out_format_type,
      out_format_mask, out_channel_count, out_subslot_size, out_resolution_bits,
      out_stopped_early}))
    else $error("result payload changed while stalled");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last_byte && !out_valid |=> out_valid)
    else $error("last byte produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_last_byte && !out_valid |=> !out_valid)
    else $error("result without a last byte");

endmodule

bind audio_streaming_descriptor_parser_core asd_checker u_asd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .in_last_byte        (in_ch.last_byte),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_terminal_link   (out_ch.terminal_link),
  .out_format_type     (out_ch.format_type),
  .out_format_mask     (out_ch.format_mask),
  .out_channel_count   (out_ch.channel_count),
  .out_subslot_size    (out_ch.subslot_size),
  .out_resolution_bits (out_ch.resolution_bits),
  .out_stopped_early   (out_ch.stopped_early)
);

@@ bench/tb_audio_streaming_descriptor_parser_core.sv @@
`timescale 1ns / 100ps
// testbench: audio streaming descriptor parser core against a byte-level parse predictor
module tb_audio_streaming_descriptor_parser_core;

  typedef struct {
    logic [7:0] data;
    logic       is_last;
    logic       drain_first;
  } byte_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  asd_in_if  in_ch ();
  asd_out_if out_ch ();

  audio_streaming_descriptor_parser_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  byte_req_t          pending_bytes[$];
  asd_pkg::result_t   owed_results[$];
  logic [7:0]         blob_bytes[$];
  bit                 failed = 1'b0;
  int                 bench_cycle = 0;
  int                 blob_count = 0;

  // parse state
  logic [7:0]     desc_offset;
  logic [7:0]     desc_len;
  logic [7:0]     desc_bytes[asd_pkg::CAPTURE_DEPTH];
  logic           parse_halted;
  asd_pkg::held_t held;

  function automatic void clear_parse();
    desc_offset  = '0;
    desc_len     = '0;
    parse_halted = 1'b0;
    held         = '0;
    foreach (desc_bytes[i]) desc_bytes[i] = '0;
  endfunction

  function automatic void fold_descriptor();
    if (desc_bytes[1] != asd_pkg::CS_IFACE_TYPE) return;
    if (desc_bytes[2] == asd_pkg::SUB_STREAM_GEN) begin
      if (desc_len >= asd_pkg::AS_GEN_FULL_LEN) begin
        held.terminal_link = desc_bytes[3];
        held.format_type   = desc_bytes[5];
        held.format_mask   = {desc_bytes[9], desc_bytes[8], desc_bytes[7], desc_bytes[6]};
        held.channel_count = desc_bytes[10];
      end else if (desc_len >= asd_pkg::AS_GEN_SHORT_LEN) begin
        held.format_type = desc_bytes[3];
      end
    end else if (desc_bytes[2] == asd_pkg::SUB_FORMAT &&
                 desc_bytes[3] == asd_pkg::FMT_TYPE_ONE) begin
      if (desc_len == asd_pkg::FMT_SHORT_LEN) begin
        held.format_type     = desc_bytes[3];
        held.subslot_size    = desc_bytes[4];
        held.resolution_bits = desc_bytes[5];
      end else if (desc_len >= asd_pkg::FMT_LONG_LEN) begin
        held.format_type     = desc_bytes[3];
        held.channel_count   = desc_bytes[4];
        held.subslot_size    = desc_bytes[5];
        held.resolution_bits = desc_bytes[6];
      end
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic is_last);
    asd_pkg::result_t r;
    if (parse_halted) begin
      if (desc_offset < 3) desc_offset++;
    end else if (desc_offset == 0) begin
      desc_len      = b;
      desc_bytes[0] = b;
      desc_offset   = 8'd1;
      if (b < asd_pkg::MIN_DESC_LEN) parse_halted = 1'b1;
    end else begin
      if (desc_offset < asd_pkg::CAPTURE_DEPTH)
        desc_bytes[desc_offset[asd_pkg::CAP_IDX_W-1:0]] = b;
      desc_offset++;
      if (desc_offset == desc_len) begin
        fold_descriptor();
        desc_offset = '0;
      end
    end
    if (is_last) begin
      r.fields        = held;
      r.stopped_early = parse_halted && desc_offset >= 3;
      owed_results    = {owed_results, r};
      clear_parse();
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic put_descriptor(input int len, input logic [7:0] dtype, input logic [7:0] sub,
                                input bit type_one);
    blob_bytes = {blob_bytes, 8'(len)};
    blob_bytes = {blob_bytes, dtype};
    blob_bytes = {blob_bytes, sub};
    for (int k = 3; k < len; k++)
      blob_bytes = {blob_bytes, (k == 3 && type_one) ? asd_pkg::FMT_TYPE_ONE : rand_byte()};
  endtask

  task automatic put_random_descriptor();
    case ($urandom_range(9))
      0, 1: put_descriptor($urandom_range(11, 13), asd_pkg::CS_IFACE_TYPE,
                           asd_pkg::SUB_STREAM_GEN, 1'b0);
      2:    put_descriptor($urandom_range(7, 10), asd_pkg::CS_IFACE_TYPE,
                           asd_pkg::SUB_STREAM_GEN, 1'b0);
      3:    put_descriptor(6, asd_pkg::CS_IFACE_TYPE, asd_pkg::SUB_FORMAT, 1'b1);
      4:    put_descriptor($urandom_range(8, 12), asd_pkg::CS_IFACE_TYPE,
                           asd_pkg::SUB_FORMAT, 1'b1);
      5: begin
        // type I with a length that sets nothing
        if ($urandom_range(1))
          put_descriptor(7, asd_pkg::CS_IFACE_TYPE, asd_pkg::SUB_FORMAT, 1'b1);
        else
          put_descriptor($urandom_range(3, 5), asd_pkg::CS_IFACE_TYPE, asd_pkg::SUB_FORMAT,
                         1'b1);
      end
      6:    put_descriptor($urandom_range(3, 12), asd_pkg::CS_IFACE_TYPE,
                           asd_pkg::SUB_FORMAT, 1'b0);
      7:    put_descriptor($urandom_range(3, 12),
                           $urandom_range(1) ? rand_byte() : asd_pkg::CS_IFACE_TYPE,
                           rand_byte(), 1'b0);
      8:    put_descriptor($urandom_range(3, 16), rand_byte(), rand_byte(), 1'b0);
      default: begin
        // long descriptor, bytes past the capture depth
        if ($urandom_range(19) == 0)
          put_descriptor(255, asd_pkg::CS_IFACE_TYPE, 8'($urandom_range(1, 2)),
                         1'($urandom_range(1)));
        else
          put_descriptor($urandom_range(12, 40), asd_pkg::CS_IFACE_TYPE,
                         8'($urandom_range(1, 2)), 1'($urandom_range(1)));
      end
    endcase
  endtask

  task automatic commit_blob(input bit drain_first);
    byte_req_t req;
    for (int i = 0; i < blob_bytes.size(); i++) begin
      req.data        = blob_bytes[i];
      req.is_last     = (i == blob_bytes.size() - 1);
      req.drain_first = (drain_first && i == 0);
      pending_bytes   = {pending_bytes, req};
    end
    blob_bytes.delete();
  endtask

  task automatic build_blob(input bit drain_first);
    int base;
    int cut;
    blob_bytes.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 20)) blob_bytes = {blob_bytes, rand_byte()};
    end else begin
      repeat ($urandom_range(0, 4)) put_random_descriptor();
      case ($urandom_range(9))
        6: begin
          // descriptor cut off by the end of the blob
          base = blob_bytes.size();
          put_random_descriptor();
          cut = $urandom_range(1, blob_bytes.size() - base - 1);
          repeat (cut) void'(blob_bytes.pop_back());
        end
        7: begin
          // short length byte, then zero to four trailing bytes
          blob_bytes = {blob_bytes, 8'($urandom_range(2))};
          repeat ($urandom_range(4)) blob_bytes = {blob_bytes, rand_byte()};
        end
        8: repeat ($urandom_range(1, 6)) blob_bytes = {blob_bytes, rand_byte()};
        default: ;
      endcase
    end
    if (blob_bytes.size() == 0) blob_bytes = {blob_bytes, rand_byte()};
    commit_blob(drain_first);
    blob_count++;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) bench_cycle <= bench_cycle + 1;

  // byte request driver
  always @(posedge clk) begin : driver
    byte_req_t nxt;
    logic      send;
    logic      calm;
    calm = bench_cycle >= 400 && bench_cycle < 800;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.last_byte <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.data_byte, in_ch.last_byte);
      if (!(in_ch.valid && !in_ch.ready)) begin
        send = 1'b0;
        if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 34) &&
            !(pending_bytes[0].drain_first && owed_results.size() != 0)) begin
          nxt  = pending_bytes.pop_front();
          send = 1'b1;
          in_ch.data_byte <= nxt.data;
          in_ch.last_byte <= nxt.is_last;
        end
        in_ch.valid <= send;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    asd_pkg::result_t want;
    logic             calm;
    calm = bench_cycle >= 400 && bench_cycle < 800;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          $error("result request with no expectation waiting");
          failed = 1'b1;
        end else begin
          want = owed_results.pop_front();
          check_field("terminal_link", 32'(want.fields.terminal_link),
                      32'(out_ch.terminal_link));
          check_field("format_type", 32'(want.fields.format_type),
                      32'(out_ch.format_type));
          check_field("format_mask", want.fields.format_mask, out_ch.format_mask);
          check_field("channel_count", 32'(want.fields.channel_count),
                      32'(out_ch.channel_count));
          check_field("subslot_size", 32'(want.fields.subslot_size),
                      32'(out_ch.subslot_size));
          check_field("resolution_bits", 32'(want.fields.resolution_bits),
                      32'(out_ch.resolution_bits));
          check_field("stopped_early", 32'(want.stopped_early),
                      32'(out_ch.stopped_early));
        end
      end
      out_ch.ready <= calm || $urandom_range(99) >= 34;
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int spin;
    clear_parse();

    // full general descriptor with extreme field values
    blob_bytes = '{8'h0B, 8'h24, 8'h01, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    commit_blob(1'b0);
    // type i short layout, then a short length byte with enough bytes after it
    blob_bytes = '{8'h06, 8'h24, 8'h02, 8'h01, 8'h00, 8'hFF, 8'h02, 8'hAA, 8'h55};
    commit_blob(1'b0);
    // zero length byte as the only byte
    blob_bytes = '{8'h00};
    commit_blob(1'b0);
    // descriptor cut off by the end of the blob
    blob_bytes = '{8'h07, 8'h24, 8'h01, 8'h80};
    commit_blob(1'b0);

    build_blob(1'b1);
    while (pending_bytes.size() < 525 || blob_count < 48)
      build_blob($urandom_range(7) == 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_ch.valid) @(posedge clk);
    spin = 0;
    while (owed_results.size() != 0 && spin < 5000) begin
      @(posedge clk);
      spin++;
    end
    repeat (8) @(posedge clk);

    if (owed_results.size() != 0) begin
      $error("%0d expected results never arrived", owed_results.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
